// ----- hw/rtl/multi_machine_dispatch_table_assert.svh -----
// Assertion macros used by the dispatch table checker
`ifndef MULTI_MACHINE_DISPATCH_TABLE_ASSERT_SVH
`define MULTI_MACHINE_DISPATCH_TABLE_ASSERT_SVH

// implication in the same cycle
`define MMDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle
`define MMDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mmdt_pkg.sv -----
// Shared types and constants of the machine dispatch table
`default_nettype none

package mmdt_pkg;

    localparam int OP_W    = 2;
    localparam int MACH_W  = 4;
    localparam int PORT_TW = 32;
    localparam int ST_W    = 2;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] ACTIVE_RST = 5'd16;

    localparam logic [OP_W-1:0] OP_FIND_IDLE   = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND_VICTIM = 2'd1;
    localparam logic [OP_W-1:0] OP_APPEND      = 2'd2;
    localparam logic [OP_W-1:0] OP_PREEMPT     = 2'd3;

    localparam logic [ST_W-1:0] ST_OK           = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE         = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_INTERVAL = 2'd2;
    localparam logic [ST_W-1:0] ST_NO_MACHINE   = 2'd3;

    localparam int IN_MACH_LSB = 0;
    localparam int IN_TIME_LSB = IN_MACH_LSB + MACH_W;
    localparam int IN_END_LSB  = IN_TIME_LSB + PORT_TW;
    localparam int IN_PROC_LSB = IN_END_LSB + PORT_TW;
    localparam int IN_REL_LSB  = IN_PROC_LSB + PORT_TW;
    localparam int IN_USED_W   = IN_REL_LSB + PORT_TW;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

    localparam int OUT_FOUND_LSB = 0;
    localparam int OUT_NEND_LSB  = OUT_FOUND_LSB + MACH_W;
    localparam int OUT_MS_LSB    = OUT_NEND_LSB + PORT_TW;
    localparam int OUT_USED_W    = OUT_MS_LSB + PORT_TW;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_DATA_W - OUT_USED_W;

    typedef struct packed {
        logic load;
        logic write;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/mmdt_ctrl.sv -----
// Sequencer of the dispatch table: accept, update, scan, deliver
`default_nettype none

module mmdt_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    output mmdt_pkg::t_cmd   o_cmd,
    input  mmdt_pkg::t_sts   i_sts
);
    import mmdt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mmdt_dpath.sv -----
// Datapath of the dispatch table: machine store, scan evaluation, result register
`default_nettype none

module mmdt_dpath #(
    parameter int MACHINES = 16,
    parameter int TIME_W   = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  mmdt_pkg::t_cmd                       i_cmd,
    output mmdt_pkg::t_sts                       o_sts,
    input  wire  [mmdt_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  wire  [mmdt_pkg::OP_W-1:0]            i_s_tuser,
    input  wire                                  i_cfg_valid,
    input  wire  [mmdt_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    output logic [mmdt_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic [mmdt_pkg::ST_W-1:0]            o_m_tuser
);
    import mmdt_pkg::*;

    localparam int IDX_W = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam int CMP_W = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;
    localparam logic [CMP_W-1:0] MACH_LIM = CMP_W'(MACHINES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MACHINES - 1);

    logic [CFG_W-1:0]    r_active,  n_active;
    logic [MACHINES-1:0] r_occ,     n_occ;
    logic [IDX_W-1:0]    r_rd_idx,  n_rd_idx;
    logic [IDX_W-1:0]    r_ev_idx;
    logic                r_ev_vld;
    logic                r_out_vld, n_out_vld;

    logic [OP_W-1:0]     r_op,      n_op;
    logic [MACH_W-1:0]   r_mach,    n_mach;
    logic [TIME_W-1:0]   r_t,       n_t;
    logic [TIME_W-1:0]   r_et,      n_et;
    logic [TIME_W-1:0]   r_pt,      n_pt;
    logic [TIME_W-1:0]   r_rel,     n_rel;
    logic [ST_W-1:0]     r_status,  n_status;
    logic [MACH_W-1:0]   r_found,   n_found;
    logic [TIME_W-1:0]   r_nend,    n_nend;
    logic                r_have,    n_have;
    logic [TIME_W-1:0]   r_best,    n_best;
    logic [TIME_W-1:0]   r_ms,      n_ms;

    logic [ST_W-1:0]     r_out_status, n_out_status;
    logic [MACH_W-1:0]   r_out_found,  n_out_found;
    logic [PORT_TW-1:0]  r_out_nend,   n_out_nend;
    logic [PORT_TW-1:0]  r_out_ms,     n_out_ms;

    logic [TIME_W-1:0]   r_end_mem [MACHINES];
    logic [TIME_W-1:0]   r_tgt_mem [MACHINES];
    logic [TIME_W-1:0]   r_rd_end;
    logic [TIME_W-1:0]   r_rd_tgt;

    logic [IDX_W-1:0]    wr_idx;
    logic                mach_oor;
    logic                we_end;
    logic                we_tgt;
    logic                ev_inr;
    logic                ev_occ;
    logic [TIME_W-1:0]   rem;

    assign wr_idx   = IDX_W'(r_mach);
    assign mach_oor = (CMP_W'(r_mach) >= CMP_W'(r_active)) || (CMP_W'(r_mach) >= MACH_LIM);
    assign ev_inr   = CMP_W'(r_ev_idx) < CMP_W'(r_active);
    assign ev_occ   = r_occ[r_ev_idx];
    assign rem      = r_rd_tgt - r_t;

    assign o_sts.scan_last = (r_rd_idx == IDX_LAST);
    assign o_sts.out_free  = !r_out_vld || i_m_tready;

    always_comb begin
        n_active     = r_active;
        n_occ        = r_occ;
        n_rd_idx     = r_rd_idx;
        n_out_vld    = r_out_vld;
        n_op         = r_op;
        n_mach       = r_mach;
        n_t          = r_t;
        n_et         = r_et;
        n_pt         = r_pt;
        n_rel        = r_rel;
        n_status     = r_status;
        n_found      = r_found;
        n_nend       = r_nend;
        n_have       = r_have;
        n_best       = r_best;
        n_ms         = r_ms;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_nend   = r_out_nend;
        n_out_ms     = r_out_ms;
        we_end       = 1'b0;
        we_tgt       = 1'b0;

        if (i_cfg_valid) begin
            n_active = i_cfg_data;
        end

        if (i_cmd.load) begin
            n_op     = i_s_tuser;
            n_mach   = i_s_tdata[IN_MACH_LSB +: MACH_W];
            n_t      = TIME_W'(i_s_tdata[IN_TIME_LSB +: PORT_TW]);
            n_et     = TIME_W'(i_s_tdata[IN_END_LSB +: PORT_TW]);
            n_pt     = TIME_W'(i_s_tdata[IN_PROC_LSB +: PORT_TW]);
            n_rel    = TIME_W'(i_s_tdata[IN_REL_LSB +: PORT_TW]);
            n_status = ST_NONE;
            n_found  = i_s_tdata[IN_MACH_LSB +: MACH_W];
            n_nend   = '0;
            n_have   = 1'b0;
            n_best   = '0;
            n_ms     = '0;
            n_rd_idx = '0;
        end else if (i_cmd.write) begin
            unique case (r_op)
                OP_APPEND: begin
                    priority if (mach_oor) begin
                        n_status = ST_NO_MACHINE;
                    end else if (r_t >= r_et) begin
                        n_status = ST_BAD_INTERVAL;
                    end else begin
                        n_status       = ST_OK;
                        n_occ[wr_idx]  = 1'b1;
                        we_end         = 1'b1;
                        we_tgt         = 1'b1;
                    end
                end
                OP_PREEMPT: begin
                    if (mach_oor || !r_occ[wr_idx]) begin
                        n_status = ST_NO_MACHINE;
                    end else begin
                        n_status = ST_OK;
                        n_nend   = r_et;
                        we_end   = 1'b1;
                    end
                end
                OP_FIND_IDLE, OP_FIND_VICTIM: begin
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.step) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end

        if (r_ev_vld) begin
            if (ev_occ && (r_rd_end > r_ms)) begin
                n_ms = r_rd_end;
            end
            if ((r_op == OP_FIND_IDLE) && (r_status == ST_NONE) && ev_inr &&
                (!ev_occ || (r_rd_end <= r_t))) begin
                n_status = ST_OK;
                n_found  = MACH_W'(r_ev_idx);
            end
            if ((r_op == OP_FIND_VICTIM) && ev_inr && ev_occ && (rem > r_pt) &&
                (!r_have || (rem < r_best))) begin
                n_status = ST_OK;
                n_have   = 1'b1;
                n_best   = rem;
                n_found  = MACH_W'(r_ev_idx);
            end
        end

        if (i_cmd.out_load) begin
            n_out_vld    = 1'b1;
            n_out_status = r_status;
            n_out_found  = r_found;
            n_out_nend   = PORT_TW'(r_nend);
            n_out_ms     = PORT_TW'(r_ms);
        end else if (i_m_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= ACTIVE_RST;
            r_occ     <= '0;
            r_rd_idx  <= '0;
            r_ev_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_occ     <= n_occ;
            r_rd_idx  <= n_rd_idx;
            r_ev_vld  <= i_cmd.step;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_mach       <= n_mach;
        r_t          <= n_t;
        r_et         <= n_et;
        r_pt         <= n_pt;
        r_rel        <= n_rel;
        r_status     <= n_status;
        r_found      <= n_found;
        r_nend       <= n_nend;
        r_have       <= n_have;
        r_best       <= n_best;
        r_ms         <= n_ms;
        r_ev_idx     <= r_rd_idx;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_nend   <= n_out_nend;
        r_out_ms     <= n_out_ms;
    end

    always_ff @(posedge i_clk) begin
        if (we_end) begin
            r_end_mem[wr_idx] <= r_et;
        end
        if (we_tgt) begin
            r_tgt_mem[wr_idx] <= r_rel + r_pt;
        end
        if (i_cmd.step) begin
            r_rd_end <= r_end_mem[r_rd_idx];
            r_rd_tgt <= r_tgt_mem[r_rd_idx];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_ms, r_out_nend, r_out_found};

endmodule

`default_nettype wire

// ----- hw/rtl/multi_machine_dispatch_table.sv -----
// Top level of the machine dispatch table.
// One item is in flight at a time: a new beat is taken only after the result is loaded.
// The scan reads one machine entry a cycle.
// Reset clears occupied bits, active count (16) and handshake state synchronously;
// end and target stores are not cleared and need no clearing pass.
`default_nettype none

module multi_machine_dispatch_table #(
    parameter int MACHINES = 16,
    parameter int TIME_W   = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // machine, request time, finish time, proc time, release time, zero pad
    input  wire  [mmdt_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // op
    input  wire  [mmdt_pkg::OP_W-1:0]            i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    // found_machine, new_end, makespan, zero pad
    output logic [mmdt_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // status
    output logic [mmdt_pkg::ST_W-1:0]            o_m_tuser,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [mmdt_pkg::CFG_W-1:0]           i_cfg_data
);
    import mmdt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    mmdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    mmdt_dpath #(
        .MACHINES (MACHINES),
        .TIME_W   (TIME_W)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mmdt_chk.sv -----
// Port-level checker of the dispatch table and its bind
`default_nettype none
`include "multi_machine_dispatch_table_assert.svh"

module mmdt_chk (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    input  wire                              o_s_tready,
    input  wire                              o_m_tvalid,
    input  wire                              i_m_tready,
    input  wire [mmdt_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  wire [mmdt_pkg::ST_W-1:0]         o_m_tuser
);
    import mmdt_pkg::*;

    logic [PORT_TW-1:0] nend;
    logic [PORT_TW-1:0] mspan;

    assign nend  = o_m_tdata[OUT_NEND_LSB +: PORT_TW];
    assign mspan = o_m_tdata[OUT_MS_LSB +: PORT_TW];

    `MMDT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result beat changed")
    `MMDT_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
        !o_s_tready, "beat accepted while an item is in flight")
    `MMDT_ASSERT_IMP(a_nend_ok, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != ST_OK),
        nend == '0, "new end set on a failed item")
    `MMDT_ASSERT_IMP(a_nend_span, i_clk, i_rst_n, o_m_tvalid && (nend != '0),
        mspan >= nend, "makespan below preempted end")

endmodule

bind multi_machine_dispatch_table mmdt_chk u_mmdt_chk (.*);

`default_nettype wire
